@@ rtl/core/dts_pkg.sv @@
`default_nettype none

package dts_pkg;

    // Default depth of the queue between the front and back parts (a power of two).
    localparam int QueueDepthDefault = 4;

    // Largest number that may stand before a unit.
    localparam logic [30:0] NumLimit = 31'h7FFF_FFFF;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_INVALID  = 2'd1,
        ST_OVERFLOW = 2'd2
    } t_status;

    // Classes of a character as seen by the back part.
    typedef enum logic [2:0] {
        K_DIGIT,
        K_UNIT,
        K_BLANK,
        K_OWS,
        K_BAD
    } t_kind;

    // Time units.
    typedef enum logic [1:0] {
        U_HOUR,
        U_MIN,
        U_SEC
    } t_unit;

    // One classified character.
    typedef struct packed {
        t_kind       kind;
        t_unit       unit;
        logic [3:0]  digit;
        logic        fin;
    } t_tok;

    // Seconds in one of each unit.
    function automatic logic [11:0] unit_scale(input t_unit u);
        logic [11:0] s;
        unique case (u)
            U_HOUR:  s = 12'd3600;
            U_MIN:   s = 12'd60;
            U_SEC:   s = 12'd1;
            default: s = 12'd1;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/dts_ifs.sv @@
`default_nettype none

// Channel carrying one character of the duration text.
interface dts_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       final_byte;

    modport source (output valid, output text_byte, output final_byte, input ready);
    modport sink   (input valid, input text_byte, input final_byte, output ready);
endinterface

// Channel carrying one parsed duration.
interface dts_res_if;
    logic        valid;
    logic        ready;
    logic [63:0] total_seconds;
    logic [1:0]  parse_status;

    modport source (output valid, output total_seconds, output parse_status, input ready);
    modport sink   (input valid, input total_seconds, input parse_status, output ready);
endinterface

`default_nettype wire

@@ rtl/core/dts_front.sv @@
`default_nettype none

module dts_front
    import dts_pkg::*;
(
    dts_in_if.sink  i_txt,
    input  wire     i_full,
    output logic    o_push,
    output t_tok    o_tok
);

    logic [7:0] w_low;

    // A transfer is taken whenever the queue has room.
    assign i_txt.ready = !i_full;
    assign o_push      = i_txt.valid && !i_full;

    // Fold upper-case letters to lower case.
    always_comb begin
        w_low = i_txt.text_byte;
        if (i_txt.text_byte >= 8'h41 && i_txt.text_byte <= 8'h5A) begin
            w_low = i_txt.text_byte + 8'd32;
        end
    end

    // Classify the character.
    always_comb begin
        o_tok.kind  = K_BAD;
        o_tok.unit  = U_SEC;
        o_tok.digit = w_low[3:0];
        o_tok.fin   = i_txt.final_byte;
        priority if (w_low == 8'h20 || w_low == 8'h09) begin
            o_tok.kind = K_BLANK;
        end else if (w_low >= 8'h0A && w_low <= 8'h0D) begin
            o_tok.kind = K_OWS;
        end else if (w_low >= 8'h30 && w_low <= 8'h39) begin
            o_tok.kind = K_DIGIT;
        end else if (w_low == 8'h68) begin
            o_tok.kind = K_UNIT;
            o_tok.unit = U_HOUR;
        end else if (w_low == 8'h6D) begin
            o_tok.kind = K_UNIT;
            o_tok.unit = U_MIN;
        end else if (w_low == 8'h73) begin
            o_tok.kind = K_UNIT;
            o_tok.unit = U_SEC;
        end else begin
            o_tok.kind = K_BAD;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/dts_queue.sv @@
`default_nettype none

module dts_queue
    import dts_pkg::*;
#(
    parameter int DEPTH = QueueDepthDefault
)
(
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_push,
    input  t_tok  i_data,
    output logic  o_full,
    input  wire   i_pop,
    output logic  o_valid,
    output t_tok  o_data
);

    localparam int PtrW = $clog2(DEPTH);
    localparam int CntW = $clog2(DEPTH + 1);

    t_tok            r_mem [DEPTH];
    logic [PtrW-1:0] r_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr;
    logic [CntW-1:0] r_count;

    assign o_full  = (r_count == CntW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    // Storage; pointers wrap naturally as the depth is a power of two.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/dts_back.sv @@
`default_nettype none

module dts_back
    import dts_pkg::*;
(
    input  wire       i_clk,
    input  wire       i_rst_n,
    input  wire       i_valid,
    input  t_tok      i_tok,
    output logic      o_pop,
    dts_res_if.source o_res
);

    logic [63:0] r_sum;
    logic [30:0] r_num;
    logic        r_open;
    logic        r_seen;
    logic        r_isp;
    t_status     r_err;
    logic        r_out_valid;
    logic [63:0] r_total;
    t_status     r_status;

    logic [63:0] n_sum;
    logic [30:0] n_num;
    logic        n_open;
    logic        n_seen;
    logic        n_isp;
    t_status     n_err;

    logic [34:0] w_num_ext;
    logic        w_unit_add;
    logic        w_tail_add;
    logic [42:0] w_addend;
    logic [64:0] w_sum_ext;
    t_status     w_err_tok;

    // A final character waits until the result register is free; others go at once.
    assign o_pop = i_valid && (!i_tok.fin || !r_out_valid || o_res.ready);

    assign o_res.valid         = r_out_valid;
    assign o_res.total_seconds = r_total;
    assign o_res.parse_status  = r_status;

    assign w_num_ext = {1'b0, r_num, 3'b000} + {3'b000, r_num, 1'b0} + {31'd0, i_tok.digit};

    // Parser state update for one character.
    always_comb begin
        n_num      = r_num;
        n_open     = r_open;
        n_seen     = r_seen;
        n_isp      = r_isp;
        w_err_tok  = r_err;
        w_unit_add = 1'b0;
        if (r_err == ST_OK) begin
            priority if (i_tok.kind == K_OWS) begin
                if (r_seen) begin
                    n_isp = 1'b1;
                end
            end else if (i_tok.kind == K_BLANK) begin
                n_isp = r_isp;
            end else if (r_isp) begin
                w_err_tok = ST_INVALID;
            end else if (i_tok.kind == K_DIGIT) begin
                n_seen = 1'b1;
                if (w_num_ext > {4'd0, NumLimit}) begin
                    w_err_tok = ST_OVERFLOW;
                end else begin
                    n_num  = w_num_ext[30:0];
                    n_open = 1'b1;
                end
            end else if (i_tok.kind == K_UNIT && r_open) begin
                n_seen     = 1'b1;
                w_unit_add = 1'b1;
                n_num      = '0;
                n_open     = 1'b0;
            end else begin
                n_seen    = 1'b1;
                w_err_tok = ST_INVALID;
            end
        end
    end

    // One scaled add into the running total: a unit, or a trailing number at the end.
    always_comb begin
        n_err      = w_err_tok;
        w_tail_add = i_tok.fin && (w_err_tok == ST_OK) && n_open;
        w_addend   = w_unit_add ? (43'(r_num) * 43'(unit_scale(i_tok.unit))) : 43'(n_num);
        w_sum_ext  = {1'b0, r_sum} + 65'(w_addend);
        n_sum      = r_sum;
        if (w_unit_add || w_tail_add) begin
            if (w_sum_ext[64]) begin
                n_err = ST_OVERFLOW;
            end else begin
                n_sum = w_sum_ext[63:0];
            end
        end
    end

    // Parser state registers; cleared after each final character.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= '0;
            r_num  <= '0;
            r_open <= 1'b0;
            r_seen <= 1'b0;
            r_isp  <= 1'b0;
            r_err  <= ST_OK;
        end else if (o_pop) begin
            if (i_tok.fin) begin
                r_sum  <= '0;
                r_num  <= '0;
                r_open <= 1'b0;
                r_seen <= 1'b0;
                r_isp  <= 1'b0;
                r_err  <= ST_OK;
            end else begin
                r_sum  <= n_sum;
                r_num  <= n_num;
                r_open <= n_open;
                r_seen <= n_seen;
                r_isp  <= n_isp;
                r_err  <= n_err;
            end
        end
    end

    // Result register handshake.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop && i_tok.fin) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload; the total reads as zero on any error.
    always_ff @(posedge i_clk) begin
        if (o_pop && i_tok.fin) begin
            r_total  <= (n_err == ST_OK) ? n_sum : 64'd0;
            r_status <= n_err;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/duration_text_to_seconds_top.sv @@
`default_nettype none

// Duration text parser. Characters of a text such as "1h 30m 5" arrive one per
// transfer on i_txt, the last one marked by final_byte; one result per text leaves
// on o_res with the total in seconds and a status (ok, invalid, overflow). The block
// takes one character every clock cycle while results are taken: a front stage
// classifies each character into a queue of QUEUE_DEPTH entries (a power of two),
// and a back stage updates the running total for each character (one multiply
// by a unit constant and one 64-bit add). A final character is first written into
// the queue; when the back stage pops it, its result is registered and then
// offered on o_res. A final character waits at the head of the queue only while
// the previous result is still held on o_res; meanwhile the characters behind it
// may still enter the queue until it fills.
module duration_text_to_seconds_top
    import dts_pkg::*;
#(
    parameter int QUEUE_DEPTH = QueueDepthDefault
)
(
    input  wire       i_clk,
    input  wire       i_rst_n,
    dts_in_if.sink    i_txt,
    dts_res_if.source o_res
);

    logic w_full;
    logic w_push;
    t_tok w_push_tok;
    logic w_q_valid;
    t_tok w_q_tok;
    logic w_pop;

    // Front: take and classify characters.
    dts_front u_front (
        .i_txt  (i_txt),
        .i_full (w_full),
        .o_push (w_push),
        .o_tok  (w_push_tok)
    );

    // Queue between classification and evaluation.
    dts_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_tok),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_data  (w_q_tok)
    );

    // Back: accumulate seconds and produce the result.
    dts_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_q_valid),
        .i_tok   (w_q_tok),
        .o_pop   (w_pop),
        .o_res   (o_res)
    );

endmodule

`default_nettype wire
